// File: sv/chg_pkg.sv
`timescale 1ns / 1ps

package chg_pkg;

   // Default build of the governor
   localparam int DEF_NUM_CORES     = 8;
   localparam int DEF_SUSPEND_CORES = 2;

   // Internal core count width: holds any count up to 16 and any 4-bit request
   localparam int CNT_W = 5;

   // Load thresholds in percent
   localparam logic [6:0] LOW_COUNT_RAISE_PCT  = 7'd30;
   localparam logic [6:0] HALF_COUNT_LOWER_PCT = 7'd15;
   localparam logic [6:0] HALF_COUNT_RAISE_PCT = 7'd80;
   localparam logic [6:0] HIGH_COUNT_LOWER_PCT = 7'd30;

   localparam logic [7:0] STREAK_MAX = 8'hFF;

   // Register indexes of the control port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_STREAK_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_STREAK_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CORES_LOCK    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CORES_LOCK    = 2'd3;
   localparam int CSR_DATA_W = 8;

   localparam logic [7:0] UP_STREAK_LIMIT_RST   = 8'd3;
   localparam logic [7:0] DOWN_STREAK_LIMIT_RST = 8'd3;

   typedef enum logic [2:0] {
      CMD_SAMPLE  = 3'd0,
      CMD_FORCE   = 3'd1,
      CMD_RELEASE = 3'd2,
      CMD_SUSPEND = 3'd3,
      CMD_RESUME  = 3'd4
   } chg_cmd_type;

   typedef struct packed {
      logic [2:0] command;
      logic [6:0] avg_load;
      logic [6:0] least_busy_load;
      logic [3:0] forced_cores;
   } chg_req_type;

   typedef struct packed {
      logic [3:0] active_cores;
      logic       count_changed;
      logic       force_held;
   } chg_rsp_type;

   typedef struct packed {
      logic [7:0] up_streak_limit;
      logic [7:0] down_streak_limit;
      logic [3:0] min_cores_lock;
      logic [3:0] max_cores_lock;
   } chg_cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] online_count;
      logic [6:0]       raise_load;
      logic [6:0]       lower_load;
      logic [7:0]       up_streak;
      logic [7:0]       down_streak;
      logic             forced_mode;
      logic             suspended_mode;
   } chg_state_type;

endpackage

// File: sv/chg_in_reg.sv
`timescale 1ns / 1ps

module chg_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  chg_pkg::chg_req_type req_data,
   input  logic               advance,
   output logic               item_valid,
   output chg_pkg::chg_req_type item_data
);
   import chg_pkg::*;

   logic        valid_ff, valid_in;
   chg_req_type data_ff;
   logic        load;

   // Hold the input while the stored item cannot move on
   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;

   // Fill on a transfer, drop when the item moves on
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// File: sv/chg_step.sv
`timescale 1ns / 1ps

module chg_step #(
   parameter int NUM_CORES     = chg_pkg::DEF_NUM_CORES,
   parameter int SUSPEND_CORES = chg_pkg::DEF_SUSPEND_CORES
) (
   input  chg_pkg::chg_req_type   req,
   input  chg_pkg::chg_state_type state,
   input  chg_pkg::chg_cfg_type   cfg,
   output chg_pkg::chg_state_type next_state,
   output chg_pkg::chg_rsp_type   rsp
);
   import chg_pkg::*;

   localparam logic [CNT_W-1:0] NUM_C  = CNT_W'(NUM_CORES);
   localparam logic [CNT_W-1:0] SUSP_C = CNT_W'(SUSPEND_CORES);
   localparam logic [CNT_W-1:0] HALF_C = CNT_W'(NUM_CORES / 2);
   localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO_C  = CNT_W'(2);

   typedef struct packed {
      logic             take;
      logic [CNT_W-1:0] count;
   } enter_type;

   function automatic logic [CNT_W-1:0] lim_cores(input logic [CNT_W-1:0] v);
      return (v > NUM_C) ? NUM_C : v;
   endfunction

   // Suspend rule, locks and range clamp for a requested count
   function automatic enter_type enter_count(
      input logic             force_req,
      input logic [CNT_W-1:0] want,
      input logic             susp,
      input logic [CNT_W-1:0] online
   );
      enter_type        res;
      logic [CNT_W-1:0] w, lo, hi;
      logic             drop;
      drop = susp && (want > SUSP_C);
      w    = (!susp && (want < SUSP_C)) ? SUSP_C : want;
      lo   = lim_cores(CNT_W'(cfg.min_cores_lock));
      hi   = lim_cores(CNT_W'(cfg.max_cores_lock));
      if (!force_req) begin
         if (lo >= ONE_C && w < lo) begin
            w = lo;
         end
         if (hi >= TWO_C && w > hi) begin
            w = hi;
         end
      end
      w = lim_cores(w);
      if (w < ONE_C) begin
         w = ONE_C;
      end
      res.take  = !drop && (w != online);
      res.count = w;
      return res;
   endfunction

   logic [CNT_W-1:0] target;
   enter_type        ent;

   always_comb begin
      next_state = state;
      target     = state.online_count;
      ent        = '0;
      case (chg_cmd_type'(req.command))
         CMD_SAMPLE: begin
            if (!state.forced_mode) begin
               // Follow the thresholds to the current count
               if (state.online_count < HALF_C) begin
                  next_state.raise_load = LOW_COUNT_RAISE_PCT;
               end else if (state.online_count == HALF_C) begin
                  next_state.raise_load = HALF_COUNT_RAISE_PCT;
                  next_state.lower_load = HALF_COUNT_LOWER_PCT;
               end else begin
                  next_state.lower_load = HIGH_COUNT_LOWER_PCT;
               end
               // Advance or clear the streaks
               if (req.avg_load <= next_state.lower_load) begin
                  if (req.least_busy_load <= next_state.lower_load) begin
                     if (state.down_streak != STREAK_MAX) begin
                        next_state.down_streak = state.down_streak + 8'd1;
                     end
                     next_state.up_streak = '0;
                  end
               end else if (req.avg_load >= next_state.raise_load) begin
                  if (state.up_streak != STREAK_MAX) begin
                     next_state.up_streak = state.up_streak + 8'd1;
                  end
                  next_state.down_streak = '0;
               end else begin
                  next_state.up_streak   = '0;
                  next_state.down_streak = '0;
               end
               // Jump up or step down
               if (next_state.up_streak > cfg.up_streak_limit) begin
                  target = (state.online_count < HALF_C) ? HALF_C : NUM_C;
               end else if (next_state.down_streak > cfg.down_streak_limit) begin
                  if (target != '0) begin
                     target = target - ONE_C;
                  end
               end
               if (target < ONE_C) begin
                  target = ONE_C;
               end
               ent = enter_count(1'b0, target, state.suspended_mode, state.online_count);
               if (ent.take) begin
                  next_state.online_count = ent.count;
                  next_state.up_streak    = '0;
                  next_state.down_streak  = '0;
               end
            end
         end
         CMD_FORCE: begin
            if (req.forced_cores != 4'd0 && CNT_W'(req.forced_cores) <= NUM_C) begin
               ent = enter_count(1'b1, CNT_W'(req.forced_cores), state.suspended_mode,
                                 state.online_count);
               if (ent.take) begin
                  next_state.online_count = ent.count;
                  next_state.up_streak    = '0;
                  next_state.down_streak  = '0;
               end
               next_state.forced_mode = 1'b1;
            end
         end
         CMD_RELEASE: begin
            next_state.forced_mode = 1'b0;
         end
         CMD_SUSPEND: begin
            next_state.suspended_mode = 1'b1;
            ent = enter_count(1'b0, SUSP_C, 1'b1, state.online_count);
            if (ent.take) begin
               next_state.online_count = ent.count;
            end
            next_state.up_streak   = '0;
            next_state.down_streak = '0;
         end
         CMD_RESUME: begin
            next_state.suspended_mode = 1'b0;
            ent = enter_count(1'b1, NUM_C, 1'b0, state.online_count);
            if (ent.take) begin
               next_state.online_count = ent.count;
               next_state.up_streak    = '0;
               next_state.down_streak  = '0;
            end
         end
         default: begin
            next_state = state;
         end
      endcase
   end

   // Report the count in effect after this item
   always_comb begin
      rsp.active_cores  = next_state.online_count[3:0];
      rsp.count_changed = (next_state.online_count != state.online_count);
      rsp.force_held    = next_state.forced_mode;
   end

endmodule

// File: sv/core_count_hotplug_governor.sv
`timescale 1ns / 1ps

// Core count governor.
// Input channel (req_*): one item per transfer, a load sample or a force,
// release, suspend or resume command. Result channel (rsp_*): exactly one
// result per input item, in order: the core count in effect, whether this
// item changed it, and whether a forced count is held.
// Control port (csr_*): write-only registers for the streak limits and the
// min/max core locks; write them only while no item is in flight.
// An item taken on the input is held in the input register; its result is then
// written to the result register, and rsp_valid rises when that register fills.
// Throughput: one item per cycle while rsp_stall is low; the whole decision is
// one pass of compare and clamp logic between the input and result registers.
// Stall: a held result keeps rsp_data stable; one further item may wait in
// the input register, after which req_stall goes high until rsp_stall drops.
// Reset: all cores online, thresholds 80/30 percent, streaks cleared, no
// force or suspend held, limits 3, no locks, both pipeline registers empty.

module core_count_hotplug_governor #(
   parameter int NUM_CORES     = chg_pkg::DEF_NUM_CORES,
   parameter int SUSPEND_CORES = chg_pkg::DEF_SUSPEND_CORES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  chg_pkg::chg_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output chg_pkg::chg_rsp_type                rsp_data,
   input  logic                                csr_wr_en,
   input  logic [chg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [chg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import chg_pkg::*;

   logic          item_valid;
   chg_req_type   item_data;
   logic          advance;
   chg_state_type state_ff, state_in;
   chg_cfg_type   cfg_ff, cfg_in;
   chg_rsp_type   step_rsp;
   chg_rsp_type   rsp_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   chg_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   chg_step #(
      .NUM_CORES     (NUM_CORES),
      .SUSPEND_CORES (SUSPEND_CORES)
   ) u_step (
      .req        (item_data),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .next_state (state_in),
      .rsp        (step_rsp)
   );

   // Move the stored item on when the result register is free or being taken
   assign advance = item_valid & (~rsp_valid_ff | ~rsp_stall);

   // Control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_UP_STREAK_LIMIT:   cfg_in.up_streak_limit   = csr_wdata[7:0];
            CSR_DOWN_STREAK_LIMIT: cfg_in.down_streak_limit = csr_wdata[7:0];
            CSR_MIN_CORES_LOCK:    cfg_in.min_cores_lock    = csr_wdata[3:0];
            CSR_MAX_CORES_LOCK:    cfg_in.max_cores_lock    = csr_wdata[3:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_streak_limit   <= UP_STREAK_LIMIT_RST;
         cfg_ff.down_streak_limit <= DOWN_STREAK_LIMIT_RST;
         cfg_ff.min_cores_lock    <= '0;
         cfg_ff.max_cores_lock    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Commit the governor state with each item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.online_count   <= CNT_W'(NUM_CORES);
         state_ff.raise_load     <= HALF_COUNT_RAISE_PCT;
         state_ff.lower_load     <= HIGH_COUNT_LOWER_PCT;
         state_ff.up_streak      <= '0;
         state_ff.down_streak    <= '0;
         state_ff.forced_mode    <= 1'b0;
         state_ff.suspended_mode <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: fill on advance, empty on an output transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Core count stays within one and all cores
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.online_count != '0 && state_ff.online_count <= CNT_W'(NUM_CORES))
      else $error("online core count out of range");

   // A count change leaves both streaks cleared
   a_change_clears_streaks: assert property (@(posedge clock) disable iff (reset)
      advance && step_rsp.count_changed |=>
         state_ff.up_streak == '0 && state_ff.down_streak == '0)
      else $error("streaks not cleared after a count change");

   // A sample while forced changes nothing
   a_forced_sample_ignored: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.forced_mode &&
         item_data.command == CMD_SAMPLE |=> $stable(state_ff))
      else $error("sample altered state while forced");

   // The result reports the committed count
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_data_ff.active_cores == state_ff.online_count[3:0] &&
         rsp_data_ff.force_held == state_ff.forced_mode)
      else $error("result disagrees with committed state");

   // A full input register with a held result blocks the input
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      item_valid && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input accepted while pipeline full");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import chg_pkg::*;

   localparam int NUM_CORES     = DEF_NUM_CORES;
   localparam int SUSPEND_CORES = DEF_SUSPEND_CORES;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned MAX_LINES   = 40;

   // Highest undefined command code; codes above CMD_RESUME are ignored
   localparam logic [2:0] CMD_UNKNOWN_TOP = 3'd7;

   typedef struct packed {
      logic        fixed;
      chg_rsp_type val;
   } status_note_type;

   typedef struct packed {
      chg_req_type item;
      logic        fixed;
      chg_rsp_type want;
   } dir_row_type;

   // Directed rows: fixed status where it is plain from the rules, else predicted
   localparam int DIR_N = 25;
   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      '{'{CMD_SAMPLE,      7'd50,  7'd50,  4'd0},  1'b1, '{4'd8, 1'b0, 1'b0}},
      '{'{CMD_UNKNOWN_TOP, 7'd127, 7'd127, 4'd15}, 1'b1, '{4'd8, 1'b0, 1'b0}},
      '{'{CMD_FORCE,       7'd0,   7'd0,   4'd0},  1'b1, '{4'd8, 1'b0, 1'b0}},
      '{'{CMD_FORCE,       7'd0,   7'd0,   4'd15}, 1'b1, '{4'd8, 1'b0, 1'b0}},
      '{'{CMD_FORCE,       7'd0,   7'd0,   4'd1},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd127, 7'd0,   4'd0},  1'b1, '{4'd2, 1'b0, 1'b1}},
      '{'{CMD_RELEASE,     7'd0,   7'd0,   4'd0},  1'b1, '{4'd2, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd0,   7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd0,   7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd0,   7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd0,   7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd30,  7'd31,  4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd127, 7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd127, 7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd127, 7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd127, 7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd100, 7'd100, 4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd100, 7'd100, 4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd100, 7'd100, 4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd100, 7'd100, 4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SUSPEND,     7'd0,   7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_FORCE,       7'd0,   7'd0,   4'd8},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_RESUME,      7'd0,   7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_RELEASE,     7'd0,   7'd0,   4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}},
      '{'{CMD_SAMPLE,      7'd79,  7'd50,  4'd0},  1'b0, '{4'd0, 1'b0, 1'b0}}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   chg_req_type            req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   chg_rsp_type            rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_UP_STREAK_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predicted governor state and register copies
   int unsigned cnt_online, thr_raise, thr_lower, up_run, down_run;
   bit          forced_hold, suspend_hold;
   int unsigned cfg_up_limit, cfg_down_limit, cfg_lo_clamp, cfg_hi_clamp;

   chg_rsp_type     status_due_q [$];
   status_note_type note_q [$];
   int unsigned     sent_count = 0;
   int unsigned     done_count = 0;
   int unsigned     err_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     stall_left = 0;
   int unsigned     rsp_hold_cycles = 0;
   bit              send_steady = 1'b0;
   bit              recv_steady = 1'b0;

   core_count_hotplug_governor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic clear_governor_model();
      cfg_up_limit   = UP_STREAK_LIMIT_RST;
      cfg_down_limit = DOWN_STREAK_LIMIT_RST;
      cfg_lo_clamp   = 0;
      cfg_hi_clamp   = 0;
      cnt_online     = NUM_CORES;
      thr_raise      = HALF_COUNT_RAISE_PCT;
      thr_lower      = HIGH_COUNT_LOWER_PCT;
      up_run         = 0;
      down_run       = 0;
      forced_hold    = 1'b0;
      suspend_hold   = 1'b0;
   endtask

   function automatic int unsigned cap_cores(int unsigned v);
      return (v > NUM_CORES) ? NUM_CORES : v;
   endfunction

   // Apply the suspend rule and the locks, then take the count if it moves
   function automatic void enter_cores(bit forced_req, int unsigned want);
      int unsigned lo, hi;
      lo = cap_cores(cfg_lo_clamp);
      hi = cap_cores(cfg_hi_clamp);
      if (suspend_hold) begin
         if (want > SUSPEND_CORES) return;
      end else if (want < SUSPEND_CORES) begin
         want = SUSPEND_CORES;
      end
      if (!forced_req) begin
         if (lo >= 1 && want < lo) want = lo;
         if (hi >= 2 && want > hi) want = hi;
      end
      want = cap_cores(want);
      if (want < 1) want = 1;
      if (want != cnt_online) begin
         up_run     = 0;
         down_run   = 0;
         cnt_online = want;
      end
   endfunction

   function automatic void apply_sample(int unsigned avg, int unsigned least);
      int unsigned cores, half;
      cores = cnt_online;
      half  = NUM_CORES / 2;
      // thresholds follow the current count
      if (cores < half) begin
         thr_raise = LOW_COUNT_RAISE_PCT;
      end else if (cores == half) begin
         thr_raise = HALF_COUNT_RAISE_PCT;
         thr_lower = HALF_COUNT_LOWER_PCT;
      end else begin
         thr_lower = HIGH_COUNT_LOWER_PCT;
      end
      // advance or drop the streaks
      if (avg <= thr_lower) begin
         if (least <= thr_lower) begin
            if (down_run < STREAK_MAX) down_run++;
            up_run = 0;
         end
      end else if (avg >= thr_raise) begin
         if (up_run < STREAK_MAX) up_run++;
         down_run = 0;
      end else begin
         up_run   = 0;
         down_run = 0;
      end
      if (up_run > cfg_up_limit) begin
         cores = (cores < half) ? half : NUM_CORES;
      end else if (down_run > cfg_down_limit) begin
         if (cores > 0) cores--;
      end
      if (cores < 1) cores = 1;
      enter_cores(1'b0, cores);
   endfunction

   // Expected status after one command
   function automatic chg_rsp_type govern_step(chg_req_type it);
      int unsigned prior;
      chg_rsp_type res;
      prior = cnt_online;
      case (it.command)
         CMD_SAMPLE: begin
            if (!forced_hold) apply_sample(it.avg_load, it.least_busy_load);
         end
         CMD_FORCE: begin
            if (it.forced_cores >= 1 && it.forced_cores <= NUM_CORES) begin
               enter_cores(1'b1, it.forced_cores);
               forced_hold = 1'b1;
            end
         end
         CMD_RELEASE: begin
            forced_hold = 1'b0;
         end
         CMD_SUSPEND: begin
            suspend_hold = 1'b1;
            enter_cores(1'b0, SUSPEND_CORES);
            up_run   = 0;
            down_run = 0;
         end
         CMD_RESUME: begin
            suspend_hold = 1'b0;
            enter_cores(1'b1, NUM_CORES);
         end
         default: ;
      endcase
      res.active_cores  = 4'(cnt_online);
      res.count_changed = (cnt_online != prior);
      res.force_held    = forced_hold;
      return res;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      err_count++;
      if (err_count <= MAX_LINES)
         $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Predict on each input transfer, check each result transfer
   always @(posedge clock) begin
      chg_rsp_type     want;
      status_note_type note;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = govern_step(req_data);
            if (note_q.size() != 0) begin
               note = note_q.pop_front();
               if (note.fixed) want = note.val;
            end
            status_due_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            done_count++;
            if (status_due_q.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_data.active_cores, 0);
            end else begin
               want = status_due_q.pop_front();
               if (rsp_data.active_cores !== want.active_cores)
                  report_mismatch("active_cores", rsp_data.active_cores, want.active_cores);
               if (rsp_data.count_changed !== want.count_changed)
                  report_mismatch("count_changed", rsp_data.count_changed,
                                  want.count_changed);
               if (rsp_data.force_held !== want.force_held)
                  report_mismatch("force_held", rsp_data.force_held, want.force_held);
            end
         end
      end
   end

   // Result side: random hold-off after each transfer, plus a requested long hold
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         stall_left = recv_steady ? 0 : $urandom_range(0, 4);
      else if (stall_left != 0)
         stall_left--;
      if (rsp_hold_cycles != 0) begin
         stall_left      = rsp_hold_cycles;
         rsp_hold_cycles = 0;
      end
      rsp_stall <= (stall_left != 0);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic chg_req_type make_req(logic [2:0] cmd, int unsigned avg,
                                            int unsigned least, int unsigned fc);
      chg_req_type it;
      it.command         = cmd;
      it.avg_load        = 7'(avg);
      it.least_busy_load = 7'(least);
      it.forced_cores    = 4'(fc);
      return it;
   endfunction

   // Offer one transfer after a random gap and hold it until taken
   task automatic send_item(chg_req_type it, bit fixed, chg_rsp_type want);
      int unsigned gap;
      gap = send_steady ? 0 : $urandom_range(0, 4);
      note_q.push_back('{fixed, want});
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Drop valid and wait for every pending result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (done_count < sent_count) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 8'(val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_UP_STREAK_LIMIT:   cfg_up_limit   = val & 8'hFF;
         CSR_DOWN_STREAK_LIMIT: cfg_down_limit = val & 8'hFF;
         CSR_MIN_CORES_LOCK:    cfg_lo_clamp   = val & 4'hF;
         CSR_MAX_CORES_LOCK:    cfg_hi_clamp   = val & 4'hF;
         default: ;
      endcase
   endtask

   task automatic set_config(int unsigned up_lim, int unsigned down_lim,
                             int unsigned lo_clamp, int unsigned hi_clamp);
      write_reg(CSR_UP_STREAK_LIMIT, up_lim);
      write_reg(CSR_DOWN_STREAK_LIMIT, down_lim);
      write_reg(CSR_MIN_CORES_LOCK, lo_clamp);
      write_reg(CSR_MAX_CORES_LOCK, hi_clamp);
   endtask

   function automatic logic [6:0] load_in_band(int unsigned band);
      case (band)
         0:       return 7'($urandom_range(0, 15));
         1:       return 7'($urandom_range(16, 30));
         2:       return 7'($urandom_range(31, 79));
         3:       return 7'($urandom_range(80, 100));
         default: return 7'($urandom_range(101, 127));
      endcase
   endfunction

   // Random traffic: loads come in runs of one band so streaks build up
   task automatic run_phase(int unsigned n_items);
      int unsigned run_left, band, pick;
      chg_req_type it;
      run_left = 0;
      band     = 0;
      for (int k = 0; k < n_items; k++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(1, 8);
            band     = $urandom_range(0, 4);
         end
         run_left--;
         it.avg_load = load_in_band(band);
         if ($urandom_range(0, 3) == 0)
            it.least_busy_load = load_in_band($urandom_range(0, 4));
         else
            it.least_busy_load = load_in_band(band);
         if ($urandom_range(0, 7) == 0)
            it.forced_cores = 4'($urandom_range(0, 15));
         else
            it.forced_cores = 4'($urandom_range(1, NUM_CORES));
         pick = $urandom_range(0, 99);
         if (pick < 78)
            it.command = CMD_SAMPLE;
         else if (pick < 84)
            it.command = CMD_FORCE;
         else if (pick < 92)
            it.command = CMD_RELEASE;
         else if (pick < 95)
            it.command = CMD_SUSPEND;
         else if (pick < 99)
            it.command = CMD_RESUME;
         else
            it.command = 3'($urandom_range(int'(CMD_RESUME) + 1, int'(CMD_UNKNOWN_TOP)));
         send_item(it, 1'b0, '0);
      end
   endtask

   initial begin
      clear_governor_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table from reset defaults
      for (int r = 0; r < DIR_N; r++)
         send_item(DIR_ROWS[r].item, DIR_ROWS[r].fixed, DIR_ROWS[r].want);
      wait_drained();

      // Zero streak limits, no locks
      set_config(0, 0, 0, 0);
      run_phase(20);
      wait_drained();

      // Long result hold while the sender keeps offering: fills the block
      set_config(3, 3, 3, 6);
      send_steady     = 1'b1;
      rsp_hold_cycles = 40;
      run_phase(20);
      send_steady = 1'b0;
      wait_drained();

      // Locks at and above the core count, no idling on either side
      set_config(1, 2, 8, 15);
      send_steady = 1'b1;
      recv_steady = 1'b1;
      run_phase(20);
      send_steady = 1'b0;
      recv_steady = 1'b0;
      wait_drained();

      // Locks of one: min acts, max does not
      set_config(2, 1, 1, 1);
      run_phase(20);
      wait_drained();

      // Min lock above the max lock
      set_config(254, 0, 15, 2);
      run_phase(20);
      wait_drained();

      set_config(1, 1, 0, 4);
      run_phase(25);
      wait_drained();

      // Saturate the up streak at two cores with a limit that never acts
      set_config(255, 255, 0, 0);
      send_item(make_req(CMD_RESUME, 0, 0, 0), 1'b0, '0);
      send_item(make_req(CMD_FORCE, 0, 0, SUSPEND_CORES), 1'b0, '0);
      send_item(make_req(CMD_RELEASE, 0, 0, 0), 1'b0, '0);
      for (int k = 0; k < 260; k++)
         send_item(make_req(CMD_SAMPLE, $urandom_range(31, 127), $urandom_range(0, 127),
                            $urandom_range(0, 15)), 1'b0, '0);
      wait_drained();
      // A saturated streak must now exceed the lowered limit
      write_reg(CSR_UP_STREAK_LIMIT, 254);
      send_item(make_req(CMD_SAMPLE, 100, 100, 0), 1'b0, '0);
      wait_drained();

      set_config(2, 3, 2, 8);
      run_phase(30);
      wait_drained();
      repeat (4) @(posedge clock);

      if (status_due_q.size() != 0)
         report_mismatch("results never seen", status_due_q.size(), 0);
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/chg_pkg.sv
sv/chg_in_reg.sv
sv/chg_step.sv
sv/core_count_hotplug_governor.sv
verif/tb_top.sv
